[hdl/msb_pkg.sv]
// msb_pkg: shared types, constants and register indexes of the mono sprite blitter
// used by msb_ctrl, msb_datapath and mono_sprite_blitter_top; no dependencies
package msb_pkg;

    // default sizing limits, handed down as top-level parameters
    localparam int MAX_SCREEN_DIM_DEF = 1024;
    localparam int MAX_SPRITE_DIM_DEF = 64;

    // fixed field widths
    localparam int SCR_DIM_W   = 11;
    localparam int SPR_DIM_W   = 7;
    localparam int COORD_W     = 11;
    localparam int FY_W        = 12;   // signed screen row/column after adding sprite offset
    localparam int ADDR_W      = 22;
    localparam int COLOUR_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    // register reset values
    localparam logic [SCR_DIM_W-1:0] SCR_W_RESET = 11'd64;
    localparam logic [SCR_DIM_W-1:0] SCR_H_RESET = 11'd32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_ALPHA_MODE    = 2'd2
    } t_cfg_idx;

    // one input transaction, unpacked
    typedef struct packed {
        logic                        first_byte;
        logic [7:0]                  frame_sel;
        logic [7:0]                  frame_total;
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic [SPR_DIM_W-1:0]        sprite_w;
        logic [SPR_DIM_W-1:0]        sprite_h;
        logic [COLOUR_W-1:0]         ink_red;
        logic [COLOUR_W-1:0]         ink_green;
        logic [COLOUR_W-1:0]         ink_blue;
        logic [7:0]                  bitmap_byte;
    } t_item;

    // one framebuffer write, unpacked
    typedef struct packed {
        logic [ADDR_W-1:0]   byte_address;
        logic                write_rgb;
        logic                write_alpha;
        logic [COLOUR_W-1:0] out_red;
        logic [COLOUR_W-1:0] out_green;
        logic [COLOUR_W-1:0] out_blue;
        logic                last_of_byte;
    } t_px;

    // controller to datapath
    typedef struct packed {
        logic load;      // input transaction accepted
        logic row_calc;  // form row base address
        logic emit;      // load the next pixel into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_wr;    // incoming byte causes at least one write
        logic last_px;   // pixel counter at last column of the byte
        logic out_free;  // output register can take a new pixel
    } t_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_EMIT
    } t_state;

endpackage

[hdl/msb_ctrl.sv]
// msb_ctrl: sequencer of the mono sprite blitter
// depends on msb_pkg; drives commands into msb_datapath
module msb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  msb_pkg::t_sts  i_sts,
    output msb_pkg::t_cmd  o_cmd
);

    msb_pkg::t_state r_state;
    msb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            msb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.has_wr) begin
                        n_state = msb_pkg::ST_ROW;
                    end
                end
            end
            msb_pkg::ST_ROW: begin
                o_cmd.row_calc = 1'b1;
                n_state        = msb_pkg::ST_EMIT;
            end
            msb_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_px) begin
                        n_state = msb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = msb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/msb_datapath.sv]
// msb_datapath: configuration registers, blit counters, row multiplier,
// pixel address unit and output register; depends on msb_pkg
module msb_datapath #(
    parameter int MAX_SCREEN_DIM = msb_pkg::MAX_SCREEN_DIM_DEF,
    parameter int MAX_SPRITE_DIM = msb_pkg::MAX_SPRITE_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [msb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  msb_pkg::t_item                     i_item,
    input  msb_pkg::t_cmd                      i_cmd,
    output msb_pkg::t_sts                      o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output msb_pkg::t_px                       o_px
);

    localparam int BW  = ((MAX_SPRITE_DIM + 7) / 8 > 1) ? $clog2((MAX_SPRITE_DIM + 7) / 8) : 1;
    localparam int RW  = $clog2(MAX_SPRITE_DIM);
    localparam int SXW = BW + 3;
    localparam int SDW = msb_pkg::SCR_DIM_W;
    localparam int PW  = msb_pkg::SPR_DIM_W;
    localparam int FW  = msb_pkg::FY_W;
    localparam int AW  = msb_pkg::ADDR_W;

    // configuration
    logic [SDW-1:0] r_scr_w;
    logic [SDW-1:0] r_scr_h;
    logic           r_alpha;

    // blit state
    logic [BW-1:0]  r_byte;
    logic [RW-1:0]  r_row;
    logic           r_rej;

    // per-byte working registers
    logic signed [FW-1:0] r_px;
    logic signed [FW-1:0] r_fy;
    logic [SXW-1:0]       r_col;
    logic [2:0]           r_last_k;
    logic [2:0]           r_k;
    logic [7:0]           r_bits;
    logic [7:0]           r_red;
    logic [7:0]           r_green;
    logic [7:0]           r_blue;
    logic [AW-1:0]        r_row_base;
    logic                 r_row_on;

    // output register
    logic                 r_out_valid;
    msb_pkg::t_px         r_px_out;

    // combinational
    logic [SDW-1:0]       w_sw;
    logic [SDW-1:0]       w_sh;
    logic [PW-1:0]        w_w;
    logic [PW-1:0]        w_h;
    logic [BW:0]          w_bpr;
    logic [BW-1:0]        w_byte;
    logic [RW-1:0]        w_row;
    logic                 w_rej;
    logic                 w_skip;
    logic [SXW-1:0]       w_col;
    logic [7:0]           w_rem;
    logic [2:0]           w_last_k;
    logic [BW:0]          w_byte_inc;
    logic [RW:0]          w_row_inc;
    logic [BW-1:0]        n_byte;
    logic [RW-1:0]        n_row;
    logic [SXW-1:0]       w_sx;
    logic signed [FW-1:0] w_fx;
    logic                 w_on;
    logic                 w_set;
    logic [AW-1:0]        w_lin;
    logic [AW-1:0]        w_addr;

    // clamped dimensions
    always_comb begin
        w_sw = (int'(r_scr_w) > MAX_SCREEN_DIM) ? SDW'(MAX_SCREEN_DIM) : r_scr_w;
        w_sh = (int'(r_scr_h) > MAX_SCREEN_DIM) ? SDW'(MAX_SCREEN_DIM) : r_scr_h;
        w_w  = (int'(i_item.sprite_w) > MAX_SPRITE_DIM) ? PW'(MAX_SPRITE_DIM)
                                                        : i_item.sprite_w;
        w_h  = (int'(i_item.sprite_h) > MAX_SPRITE_DIM) ? PW'(MAX_SPRITE_DIM)
                                                        : i_item.sprite_h;
        w_bpr = (BW + 1)'((8'(w_w) + 8'd7) >> 3);
    end

    // counter evaluation for the incoming byte
    always_comb begin
        w_byte     = i_item.first_byte ? '0 : r_byte;
        w_row      = i_item.first_byte ? '0 : r_row;
        w_rej      = i_item.first_byte ? (i_item.frame_sel >= i_item.frame_total) : r_rej;
        w_skip     = (w_w == '0) || (w_h == '0) || ({1'b0, w_byte} >= w_bpr)
                     || (w_row >= w_h);
        w_col      = {w_byte, 3'b000};
        w_rem      = 8'(w_w) - 8'(w_col);
        w_last_k   = (w_rem >= 8'd8) ? 3'd7 : 3'(w_rem - 8'd1);
        w_byte_inc = {1'b0, w_byte} + 1'b1;
        w_row_inc  = {1'b0, w_row} + 1'b1;
        n_byte     = '0;
        n_row      = '0;
        if (!w_skip) begin
            if (w_byte_inc >= w_bpr) begin
                if (w_row_inc < w_h) begin
                    n_row = w_row_inc[RW-1:0];
                end
            end else begin
                n_byte = w_byte_inc[BW-1:0];
                n_row  = w_row;
            end
        end
    end

    // pixel address unit
    always_comb begin
        w_sx   = r_col + SXW'(r_k);
        w_fx   = r_px + $signed(FW'(w_sx));
        w_on   = r_row_on && !w_fx[FW-1] && (w_fx < $signed({1'b0, w_sw}));
        w_set  = r_bits[3'd7 - r_k];
        w_lin  = r_row_base + AW'(w_fx[SDW-1:0]);
        w_addr = r_alpha ? {w_lin[AW-3:0], 2'b00} : (w_lin + {w_lin[AW-2:0], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= msb_pkg::SCR_W_RESET;
            r_scr_h <= msb_pkg::SCR_H_RESET;
            r_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msb_pkg::CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                msb_pkg::CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
                msb_pkg::CFG_ALPHA_MODE:    r_alpha <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
            r_row  <= '0;
            r_rej  <= 1'b0;
            r_k    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_byte <= n_byte;
                r_row  <= n_row;
                r_rej  <= w_rej;
                r_k    <= '0;
            end else if (i_cmd.emit) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= FW'(i_item.pos_x);
            r_fy     <= FW'(i_item.pos_y) + $signed(FW'(w_row));
            r_col    <= w_col;
            r_last_k <= w_last_k;
            r_bits   <= i_item.bitmap_byte;
            r_red    <= i_item.ink_red;
            r_green  <= i_item.ink_green;
            r_blue   <= i_item.ink_blue;
        end
        if (i_cmd.row_calc) begin
            r_row_base <= AW'(r_fy[SDW-1:0]) * AW'(w_sw);
            r_row_on   <= !r_fy[FW-1] && (r_fy < $signed({1'b0, w_sh}));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px_out.byte_address <= w_on ? w_addr : '0;
            r_px_out.write_rgb    <= w_on && w_set;
            r_px_out.write_alpha  <= w_on && r_alpha;
            r_px_out.out_red      <= (w_on && w_set) ? r_red : '0;
            r_px_out.out_green    <= (w_on && w_set) ? r_green : '0;
            r_px_out.out_blue     <= (w_on && w_set) ? r_blue : '0;
            r_px_out.last_of_byte <= (r_k == r_last_k);
        end
    end

    assign o_sts.has_wr   = !w_skip && !w_rej;
    assign o_sts.last_px  = (r_k == r_last_k);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_px           = r_px_out;

endmodule

[hdl/mono_sprite_blitter_top.sv]
// mono_sprite_blitter_top: clipped blit of a 1-bit sprite into an RGB/RGBA framebuffer
// depends on msb_pkg, msb_ctrl and msb_datapath
//
// usage
//   the slave stream carries one bitmap byte per transaction, msb leftmost, rows
//   padded to whole bytes; every byte repeats position, size, colour and frame
//   numbers, and tuser marks the first byte of a blit (counters restart there)
//   the master stream carries one framebuffer write per transaction, in column
//   order, with tlast on the last write caused by a byte
//   a byte of a blit whose first frame number is at or above its frame count, or a
//   byte that falls outside the sprite, causes no writes and leaves the block idle
//   a byte with n writes (n up to 8) is accepted in the idle state, the row base address
//   is formed by the 11x11 row multiplier in the cycle after, then the pixel address
//   unit emits one write per cycle to the output register while the receiver keeps up
//   a stalled receiver holds the write in the output register; the next pixel
//   waits in the address unit and the slave side stays not ready until all
//   writes of the current byte have been loaded
//   configuration is a plain write port, written while the block is idle
//   synchronous active-low reset: screen 64x32, rgb mode, counters cleared
module mono_sprite_blitter_top #(
    parameter int MAX_SCREEN_DIM = msb_pkg::MAX_SCREEN_DIM_DEF,
    parameter int MAX_SPRITE_DIM = msb_pkg::MAX_SPRITE_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [msb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // bitmap byte stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_sel[7:0], frame_total[15:8], pos_x[26:16], pos_y[37:27],
    // sprite_w[44:38], sprite_h[51:45], ink_red[59:52], ink_green[67:60],
    // ink_blue[75:68], bitmap_byte[83:76], zero pad[87:84]
    input  logic [msb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // first_byte[0]
    input  logic                               s_axis_tuser,
    // framebuffer write stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // byte_address[21:0], out_red[29:22], out_green[37:30], out_blue[45:38],
    // zero pad[47:46]
    output logic [msb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // write_rgb[0], write_alpha[1]
    output logic [msb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    // last_of_byte
    output logic                               m_axis_tlast
);

    msb_pkg::t_item w_item;
    msb_pkg::t_cmd  w_cmd;
    msb_pkg::t_sts  w_sts;
    msb_pkg::t_px   w_px;

    // unpack the slave transaction
    always_comb begin
        w_item.first_byte  = s_axis_tuser;
        w_item.frame_sel   = s_axis_tdata[7:0];
        w_item.frame_total = s_axis_tdata[15:8];
        w_item.pos_x       = s_axis_tdata[26:16];
        w_item.pos_y       = s_axis_tdata[37:27];
        w_item.sprite_w    = s_axis_tdata[44:38];
        w_item.sprite_h    = s_axis_tdata[51:45];
        w_item.ink_red     = s_axis_tdata[59:52];
        w_item.ink_green   = s_axis_tdata[67:60];
        w_item.ink_blue    = s_axis_tdata[75:68];
        w_item.bitmap_byte = s_axis_tdata[83:76];
    end

    // sequencer: idle, row base, pixel emission
    msb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // counters, address arithmetic and output register
    msb_datapath #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_px        (w_px)
    );

    // pack the master transaction
    assign m_axis_tdata = {2'b00, w_px.out_blue, w_px.out_green, w_px.out_red,
                           w_px.byte_address};
    assign m_axis_tuser = {w_px.write_alpha, w_px.write_rgb};
    assign m_axis_tlast = w_px.last_of_byte;

endmodule

[tb/sv/tb.sv]
// tb: self-checking bench for mono_sprite_blitter_top, drives bitmap bytes and checks every
// framebuffer write against its own blit predictor, under several screen settings and idling
// depends on msb_pkg and the blitter rtl only
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;      // margin after the last owed write arrives
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SPR_MAX       = msb_pkg::MAX_SPRITE_DIM_DEF;
    localparam int SCR_MAX       = msb_pkg::MAX_SCREEN_DIM_DEF;
    localparam int AW            = msb_pkg::ADDR_W;
    localparam int CDW           = msb_pkg::CFG_DATA_W;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [msb_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [msb_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [msb_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [msb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [msb_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                            m_axis_tlast;

    mono_sprite_blitter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // framebuffer writes still owed by the block, oldest first
    msb_pkg::t_px px_expect_q[$];

    // predictor copy of the blit counters and of the screen registers
    int blit_col     = 0;
    int blit_row     = 0;
    bit blit_reject  = 1'b0;
    int scr_w_reg    = 64;
    int scr_h_reg    = 32;
    bit rgba_reg     = 1'b0;

    // idling percentages, per cycle
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    int err_cnt       = 0;
    int bytes_sent    = 0;
    int writes_seen   = 0;
    int settings_used = 0;
    int cycle_cnt     = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // one line per mismatch, printing capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("mismatch %0d at %0t: %s got 0x%0h expected 0x%0h",
                     err_cnt, $time, what, got, want);
    endtask

    // blit predictor: updates the counters for one accepted bitmap byte and queues
    // the framebuffer writes that it causes, in column order
    task automatic predict_writes(input msb_pkg::t_item it);
        int w, h, sw, sh, bpp, bpr, sx, fx, fy, k;
        bit on_scr;
        msb_pkg::t_px wr;
        w   = (int'(it.sprite_w) > SPR_MAX) ? SPR_MAX : int'(it.sprite_w);
        h   = (int'(it.sprite_h) > SPR_MAX) ? SPR_MAX : int'(it.sprite_h);
        sw  = (scr_w_reg > SCR_MAX) ? SCR_MAX : scr_w_reg;
        sh  = (scr_h_reg > SCR_MAX) ? SCR_MAX : scr_h_reg;
        bpp = rgba_reg ? 4 : 3;
        bpr = (w + 7) / 8;
        if (it.first_byte) begin
            blit_col    = 0;
            blit_row    = 0;
            blit_reject = (it.frame_sel >= it.frame_total);
        end
        // zero size or counters outside the sprite: nothing drawn, counters restart
        if (w == 0 || h == 0 || blit_col >= bpr || blit_row >= h) begin
            blit_col = 0;
            blit_row = 0;
            return;
        end
        if (!blit_reject) begin
            fy = int'($signed(it.pos_y)) + blit_row;
            for (k = 0; k < 8; k++) begin
                sx = blit_col * 8 + k;
                if (sx >= w)
                    break;
                fx = int'($signed(it.pos_x)) + sx;
                on_scr = fx >= 0 && fx < sw && fy >= 0 && fy < sh;
                wr.byte_address = on_scr ? AW'((fy * sw + fx) * bpp) : '0;
                wr.write_rgb    = on_scr && it.bitmap_byte[7-k];
                wr.write_alpha  = on_scr && rgba_reg;
                wr.out_red      = wr.write_rgb ? it.ink_red   : '0;
                wr.out_green    = wr.write_rgb ? it.ink_green : '0;
                wr.out_blue     = wr.write_rgb ? it.ink_blue  : '0;
                wr.last_of_byte = (k == 7) || (sx + 1 >= w);
                px_expect_q.push_back(wr);
            end
        end
        // surplus bytes wrap back to the top row
        blit_col++;
        if (blit_col >= bpr) begin
            blit_col = 0;
            blit_row++;
            if (blit_row >= h)
                blit_row = 0;
        end
    endtask

    // builds one bitmap byte transaction; ink is {red, green, blue}
    function automatic msb_pkg::t_item mk_item(input bit fb, input int fsel, input int ftot,
                                               input int x, input int y, input int w,
                                               input int h, input logic [23:0] ink,
                                               input logic [7:0] bits);
        msb_pkg::t_item it;
        it.first_byte  = fb;
        it.frame_sel   = 8'(fsel);
        it.frame_total = 8'(ftot);
        it.pos_x       = 11'(x);
        it.pos_y       = 11'(y);
        it.sprite_w    = 7'(w);
        it.sprite_h    = 7'(h);
        it.ink_red     = ink[23:16];
        it.ink_green   = ink[15:8];
        it.ink_blue    = ink[7:0];
        it.bitmap_byte = bits;
        return it;
    endfunction

    // sends one bitmap byte; tvalid is left high so back-to-back transactions need
    // no extra edge, the next call or wait_idle decides whether it drops
    task automatic send_bitmap_byte(input msb_pkg::t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.first_byte;
        s_axis_tdata  <= {4'b0, it.bitmap_byte, it.ink_blue, it.ink_green, it.ink_red,
                          it.sprite_h, it.sprite_w, it.pos_y, it.pos_x,
                          it.frame_total, it.frame_sel};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_writes(it);
        bytes_sent++;
    endtask

    // stop sending, let every owed write arrive, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (px_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all three registers while the block is idle
    task automatic set_screen(input int width, input int height, input bit rgba);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= msb_pkg::CFG_SCREEN_WIDTH;
        i_cfg_data <= CDW'(width);
        @(posedge i_clk);
        i_cfg_idx  <= msb_pkg::CFG_SCREEN_HEIGHT;
        i_cfg_data <= CDW'(height);
        @(posedge i_clk);
        i_cfg_idx  <= msb_pkg::CFG_ALPHA_MODE;
        i_cfg_data <= CDW'(rgba);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scr_w_reg = width & 'h7FF;
        scr_h_reg = height & 'h7FF;
        rgba_reg  = rgba;
        settings_used++;
    endtask

    // receiver: random back-pressure on the write stream
    initial begin : write_sink
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // checks each accepted write against the oldest expectation, field by field
    always @(posedge i_clk) begin : write_checker
        msb_pkg::t_px got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.byte_address = m_axis_tdata[21:0];
            got.out_red      = m_axis_tdata[29:22];
            got.out_green    = m_axis_tdata[37:30];
            got.out_blue     = m_axis_tdata[45:38];
            got.write_rgb    = m_axis_tuser[0];
            got.write_alpha  = m_axis_tuser[1];
            got.last_of_byte = m_axis_tlast;
            writes_seen++;
            if (px_expect_q.size() == 0) begin
                report_mismatch("write with none expected, address",
                                longint'(got.byte_address), 64'sd0);
            end else begin
                want = px_expect_q.pop_front();
                if (got.byte_address !== want.byte_address)
                    report_mismatch("byte_address", longint'(got.byte_address),
                                    longint'(want.byte_address));
                if (got.write_rgb !== want.write_rgb)
                    report_mismatch("write_rgb", longint'(got.write_rgb),
                                    longint'(want.write_rgb));
                if (got.write_alpha !== want.write_alpha)
                    report_mismatch("write_alpha", longint'(got.write_alpha),
                                    longint'(want.write_alpha));
                if (got.out_red !== want.out_red)
                    report_mismatch("out_red", longint'(got.out_red),
                                    longint'(want.out_red));
                if (got.out_green !== want.out_green)
                    report_mismatch("out_green", longint'(got.out_green),
                                    longint'(want.out_green));
                if (got.out_blue !== want.out_blue)
                    report_mismatch("out_blue", longint'(got.out_blue),
                                    longint'(want.out_blue));
                if (got.last_of_byte !== want.last_of_byte)
                    report_mismatch("last_of_byte", longint'(got.last_of_byte),
                                    longint'(want.last_of_byte));
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d writes still awaited",
                 cycle_cnt, px_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // bytes before any blit start use the counters as reset left them
    task automatic test_loose_bytes();
        send_bitmap_byte(mk_item(0, 0, 0, 60, 31, 8, 2, 24'hFFFFFF, 8'hA5));
    endtask

    // field extremes, zero sizes, rejected frames, oversized sprites
    task automatic test_edge_fields();
        send_bitmap_byte(mk_item(1, 0, 1, 0, 0, 8, 1, 24'h000000, 8'hFF));
        send_bitmap_byte(mk_item(1, 254, 255, 63, 31, 1, 1, 24'hFFFFFF, 8'h80));
        // zero width, then zero height
        send_bitmap_byte(mk_item(1, 0, 1, 2, 2, 0, 5, 24'h808080, 8'hFF));
        send_bitmap_byte(mk_item(1, 0, 1, 2, 2, 5, 0, 24'h808080, 8'hFF));
        // frame at the count: whole blit rejected, also for a later byte
        send_bitmap_byte(mk_item(1, 255, 255, 0, 0, 8, 2, 24'h112233, 8'hFF));
        send_bitmap_byte(mk_item(0, 255, 255, 0, 0, 8, 2, 24'h112233, 8'hFF));
        send_bitmap_byte(mk_item(1, 0, 0, 0, 0, 8, 2, 24'h112233, 8'hFF));
        // oversized sprite saturates, far corners entirely off screen
        send_bitmap_byte(mk_item(1, 3, 200, -1024, -1024, 127, 127, 24'hC0FFEE, 8'hAA));
        send_bitmap_byte(mk_item(0, 3, 200, 1023, 1023, 127, 127, 24'hC0FFEE, 8'h55));
    endtask

    // two bytes per row, left clipping, then one surplus byte wraps
    task automatic test_clip_and_wrap();
        send_bitmap_byte(mk_item(1, 1, 2, -4, 30, 12, 2, 24'h123456, 8'h55));
        send_bitmap_byte(mk_item(0, 1, 2, -4, 30, 12, 2, 24'h123456, 8'hF0));
        send_bitmap_byte(mk_item(0, 1, 2, -4, 30, 12, 2, 24'h123456, 8'h0F));
        send_bitmap_byte(mk_item(0, 1, 2, -4, 30, 12, 2, 24'h123456, 8'hFF));
        send_bitmap_byte(mk_item(0, 1, 2, -4, 30, 12, 2, 24'h123456, 8'h81));
    endtask

    // size shrinks mid-blit so the byte counter lands outside the sprite
    task automatic test_counter_overrun();
        send_bitmap_byte(mk_item(1, 0, 9, 10, 5, 16, 2, 24'h00FF00, 8'h3C));
        send_bitmap_byte(mk_item(0, 0, 9, 10, 5, 8, 2, 24'h00FF00, 8'hC3));
        send_bitmap_byte(mk_item(0, 0, 9, 10, 5, 8, 2, 24'h00FF00, 8'h7E));
    endtask

    // register extremes: one-pixel screen, zero width, saturated and largest screens
    task automatic test_screen_extremes();
        set_screen(1, 1, 1'b1);
        send_bitmap_byte(mk_item(1, 0, 1, -1, 0, 3, 1, 24'hFF0000, 8'hE0));
        send_bitmap_byte(mk_item(1, 0, 1, 0, -1, 2, 2, 24'h0000FF, 8'h40));
        send_bitmap_byte(mk_item(0, 0, 1, 0, -1, 2, 2, 24'h0000FF, 8'hC0));
        set_screen(0, 5, 1'b0);
        send_bitmap_byte(mk_item(1, 0, 1, 0, 0, 4, 1, 24'hFFFFFF, 8'hF0));
        set_screen(2047, 2047, 1'b1);
        send_bitmap_byte(mk_item(1, 0, 1, 1020, 1023, 8, 1, 24'hA5A5A5, 8'hFF));
        send_bitmap_byte(mk_item(1, 0, 1, 1023, 1023, 1, 1, 24'h5A5A5A, 8'h80));
        set_screen(1024, 1024, 1'b0);
        send_bitmap_byte(mk_item(1, 0, 1, 1016, 1022, 16, 1, 24'h010203, 8'h99));
        send_bitmap_byte(mk_item(0, 0, 1, 1016, 1022, 16, 1, 24'h010203, 8'h66));
    endtask

    // mostly well-formed blits with random content; a few drop the start marker,
    // change size mid-blit or add a surplus byte
    task automatic test_random_blits(input int snd_pct, input int rcv_pct, input int n_bytes);
        msb_pkg::t_item it;
        int budget, wc, hc, nb, b, r;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        budget = n_bytes;
        while (budget > 0) begin
            it.frame_total = 8'($urandom_range(255));
            if ($urandom_range(99) < 80 && it.frame_total != 0)
                it.frame_sel = 8'($urandom_range(int'(it.frame_total) - 1));
            else
                it.frame_sel = 8'($urandom_range(255));
            r = int'($urandom_range(99));
            it.sprite_w = (r < 80) ? 7'($urandom_range(16, 1)) :
                          (r < 94) ? 7'($urandom_range(127, 17)) : 7'd0;
            r = int'($urandom_range(99));
            it.sprite_h = (r < 85) ? 7'($urandom_range(3, 1)) :
                          (r < 95) ? 7'($urandom_range(127, 4)) : 7'd0;
            if ($urandom_range(99) < 75) begin
                it.pos_x = 11'(int'($urandom_range(scr_w_reg + 8)) - 8);
                it.pos_y = 11'(int'($urandom_range(scr_h_reg + 4)) - 4);
            end else begin
                it.pos_x = 11'($urandom_range(2047));
                it.pos_y = 11'($urandom_range(2047));
            end
            {it.ink_red, it.ink_green, it.ink_blue} = 24'($urandom);
            wc = (int'(it.sprite_w) > SPR_MAX) ? SPR_MAX : int'(it.sprite_w);
            hc = (int'(it.sprite_h) > SPR_MAX) ? SPR_MAX : int'(it.sprite_h);
            nb = ((wc + 7) / 8) * hc;
            if (nb > 6 || nb == 0)
                nb = int'($urandom_range(6, 2));
            if ($urandom_range(99) < 15)
                nb++;
            for (b = 0; b < nb && budget > 0; b++) begin
                it.first_byte  = (b == 0) && ($urandom_range(99) >= 8);
                it.bitmap_byte = 8'($urandom);
                if ($urandom_range(99) < 4)
                    it.sprite_w = 7'($urandom_range(127));
                send_bitmap_byte(it);
                budget--;
            end
        end
    endtask

    // stimulus sequence
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= msb_pkg::CFG_SCREEN_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset screen until the screen extremes, no idling
        test_loose_bytes();
        test_edge_fields();
        test_clip_and_wrap();
        test_counter_overrun();
        test_screen_extremes();

        // random part, one screen setting and one idling pattern per phase
        set_screen(100, 60, 1'b0);
        test_random_blits(0, 0, 21);
        set_screen(64, 32, 1'b1);
        test_random_blits(55, 0, 21);
        set_screen(320, 200, 1'b1);
        test_random_blits(0, 55, 21);
        set_screen(17, 9, 1'b0);
        test_random_blits(13, 13, 21);

        wait_idle();
        $display("summary: %0d bitmap bytes, %0d framebuffer writes checked, %0d screen settings",
                 bytes_sent, writes_seen, settings_used);
        $display("covered: clipping on every edge, rejected frames, zero and oversized sizes,"
                 , " row wrap, rgb and rgba, sender and receiver idling");
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
